FILE: design/lease_consensus_acceptor_assert.svh
// ----------------------------------------------------------------------------
// lease_consensus_acceptor_assert.svh
// Assertion macros used by the lease acceptor top level.
// ----------------------------------------------------------------------------
`ifndef LEASE_CONSENSUS_ACCEPTOR_ASSERT_SVH
`define LEASE_CONSENSUS_ACCEPTOR_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define LCA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The condition must hold in the cycle after the trigger.
`define LCA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/lca_pkg.sv
// ----------------------------------------------------------------------------
// lca_pkg
// Types and codes shared by the lease acceptor modules.
// ----------------------------------------------------------------------------
package lca_pkg;

  // Message codes carried in the command field.
  typedef enum logic [1:0] {
    CMD_PREPARE = 2'd0,
    CMD_PROPOSE = 2'd1,
    CMD_TICK    = 2'd2
  } lca_cmd_t;

  // Reply codes placed in the reply_kind field.
  typedef enum logic [2:0] {
    KIND_PREP_REJECT = 3'd0,
    KIND_PREP_OPEN   = 3'd1,
    KIND_PREP_ACCEPT = 3'd2,
    KIND_PROP_REJECT = 3'd3,
    KIND_PROP_ACCEPT = 3'd4
  } lca_kind_t;

  // One incoming message.
  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  sender_id;
    logic [31:0] proposal_number;
    logic [7:0]  lease_owner;
    logic [23:0] lease_duration;
  } lca_item_t;

  // One response.
  typedef struct packed {
    logic [7:0]  destination;
    logic [7:0]  responder;
    lca_kind_t   reply_kind;
    logic [31:0] echoed_proposal;
    logic [31:0] held_proposal;
    logic [7:0]  held_owner;
    logic [23:0] held_duration;
  } lca_result_t;

  // Acceptor state visible to the top level.
  typedef struct packed {
    logic        has_accepted;
    logic [23:0] lease_left;
    logic [31:0] promised_number;
  } lca_status_t;

endpackage

FILE: design/lca_input_reg.sv
// ----------------------------------------------------------------------------
// lca_input_reg
// Input register stage: holds one accepted message until the core takes it.
// ----------------------------------------------------------------------------
module lca_input_reg
  import lca_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  lca_item_t in_item,
  input  logic      advance,
  output logic      held_valid,
  output lca_item_t held_item
);

  // The stage can take a new beat when empty or when its item moves on.
  assign in_ready = !held_valid || advance;

  // Occupancy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  // Payload capture.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

FILE: design/lca_core.sv
// ----------------------------------------------------------------------------
// lca_core
// Acceptor state and the decision logic for prepare, propose and tick.
// ----------------------------------------------------------------------------
module lca_core
  import lca_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        take,
  input  lca_item_t   item,
  output logic        gives_result,
  output lca_result_t result,
  output lca_status_t status
);

  logic [7:0]  own_node;
  logic [31:0] promised_number;
  logic        has_accepted;
  logic [31:0] accepted_number;
  logic [7:0]  accepted_owner;
  logic [23:0] accepted_length;
  logic [23:0] lease_left;

  logic [31:0] promised_number_next;
  logic        has_accepted_next;
  logic [31:0] accepted_number_next;
  logic [7:0]  accepted_owner_next;
  logic [23:0] accepted_length_next;
  logic [23:0] lease_left_next;
  logic        below_promise;

  // Only prepare and propose messages are answered.
  assign gives_result = item.command inside {CMD_PREPARE, CMD_PROPOSE};
  assign below_promise = item.proposal_number < promised_number;

  // Decision and next state for the message in the input register.
  always_comb begin
    promised_number_next = promised_number;
    has_accepted_next    = has_accepted;
    accepted_number_next = accepted_number;
    accepted_owner_next  = accepted_owner;
    accepted_length_next = accepted_length;
    lease_left_next      = lease_left;

    result.destination     = item.sender_id;
    result.responder       = own_node;
    result.reply_kind      = KIND_PREP_REJECT;
    result.echoed_proposal = item.proposal_number;
    result.held_proposal   = '0;
    result.held_owner      = '0;
    result.held_duration   = '0;

    case (item.command)
      CMD_PREPARE: begin
        if (!below_promise) begin
          promised_number_next = item.proposal_number;
          if (has_accepted) begin
            result.reply_kind    = KIND_PREP_ACCEPT;
            result.held_proposal = accepted_number;
            result.held_owner    = accepted_owner;
            result.held_duration = accepted_length;
          end else begin
            result.reply_kind = KIND_PREP_OPEN;
          end
        end
      end
      CMD_PROPOSE: begin
        if (below_promise) begin
          result.reply_kind = KIND_PROP_REJECT;
        end else begin
          result.reply_kind    = KIND_PROP_ACCEPT;
          has_accepted_next    = 1'b1;
          accepted_number_next = item.proposal_number;
          accepted_owner_next  = item.lease_owner;
          accepted_length_next = item.lease_duration;
          lease_left_next      = item.lease_duration;
        end
      end
      CMD_TICK: begin
        // The lease expires on the tick that finds one or zero left.
        if (has_accepted) begin
          if (lease_left <= 24'd1) begin
            lease_left_next   = '0;
            has_accepted_next = 1'b0;
          end else begin
            lease_left_next = lease_left - 24'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      own_node <= '0;
    end else if (cfg_we) begin
      own_node <= cfg_wdata;
    end
  end

  // Acceptor state, updated as each message leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      promised_number <= '0;
      has_accepted    <= 1'b0;
      accepted_number <= '0;
      accepted_owner  <= '0;
      accepted_length <= '0;
      lease_left      <= '0;
    end else if (take) begin
      promised_number <= promised_number_next;
      has_accepted    <= has_accepted_next;
      accepted_number <= accepted_number_next;
      accepted_owner  <= accepted_owner_next;
      accepted_length <= accepted_length_next;
      lease_left      <= lease_left_next;
    end
  end

  assign status.has_accepted    = has_accepted;
  assign status.lease_left      = lease_left;
  assign status.promised_number = promised_number;

endmodule

FILE: design/lca_result_reg.sv
// ----------------------------------------------------------------------------
// lca_result_reg
// Output register: holds one response until the consumer takes the beat.
// ----------------------------------------------------------------------------
module lca_result_reg
  import lca_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  lca_result_t result,
  output logic        slot_free,
  input  logic        out_ready,
  output logic        out_valid,
  output lca_result_t out_result
);

  // Free when empty or when the waiting beat leaves this cycle.
  assign slot_free = !out_valid || out_ready;

  // Occupancy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload capture.
  always_ff @(posedge clk) begin
    if (load) begin
      out_result <= result;
    end
  end

endmodule

FILE: design/lease_consensus_acceptor.sv
// ----------------------------------------------------------------------------
// lease_consensus_acceptor
// Lease acceptor: answers prepare and propose messages, counts the lease down.
// ----------------------------------------------------------------------------
//   Channel   Handshake              Payload
//   input     in_valid / in_ready    command, sender_id, proposal_number,
//                                    lease_owner, lease_duration
//   output    out_valid / out_ready  destination .. held_duration
//   config    cfg_we                 cfg_wdata (own_node)
//
// A message is held in the input register, and its response is loaded into
// the output register as the message leaves. One beat per cycle is sustained
// while the output is not stalled. The acceptor state is updated as a message
// leaves the input register, so each message sees the state left by the one
// before. Reset clears all state and both register stages. A stalled output
// blocks only prepare and propose messages; ticks pass through regardless.
// ----------------------------------------------------------------------------
module lease_consensus_acceptor
  import lca_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [7:0]  sender_id,
  input  logic [31:0] proposal_number,
  input  logic [7:0]  lease_owner,
  input  logic [23:0] lease_duration,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  destination,
  output logic [7:0]  responder,
  output logic [2:0]  reply_kind,
  output logic [31:0] echoed_proposal,
  output logic [31:0] held_proposal,
  output logic [7:0]  held_owner,
  output logic [23:0] held_duration
);

`include "lease_consensus_acceptor_assert.svh"

  lca_item_t   in_item;
  lca_item_t   s1_item;
  logic        s1_valid;
  logic        advance;
  logic        gives_result;
  logic        slot_free;
  lca_result_t result;
  lca_result_t out_result;
  lca_status_t status;

  assign in_item.command         = command;
  assign in_item.sender_id       = sender_id;
  assign in_item.proposal_number = proposal_number;
  assign in_item.lease_owner     = lease_owner;
  assign in_item.lease_duration  = lease_duration;

  // A message moves on unless its response has nowhere to go.
  assign advance = s1_valid && (!gives_result || slot_free);

  lca_input_reg u_input_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (advance),
    .held_valid (s1_valid),
    .held_item  (s1_item)
  );

  lca_core u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .take         (advance),
    .item         (s1_item),
    .gives_result (gives_result),
    .result       (result),
    .status       (status)
  );

  lca_result_reg u_result_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (advance && gives_result),
    .result     (result),
    .slot_free  (slot_free),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  assign destination     = out_result.destination;
  assign responder       = out_result.responder;
  assign reply_kind      = out_result.reply_kind;
  assign echoed_proposal = out_result.echoed_proposal;
  assign held_proposal   = out_result.held_proposal;
  assign held_owner      = out_result.held_owner;
  assign held_duration   = out_result.held_duration;

  // Checks on the acceptor's own logic.
  `LCA_ASSERT_SAME(a_idle_lease_empty, !status.has_accepted, status.lease_left == 24'd0, "lease count left without a lease")
  `LCA_ASSERT_NEXT(a_prepare_raises_promise, advance && (s1_item.command == CMD_PREPARE) && (result.reply_kind != KIND_PREP_REJECT), status.promised_number == $past(s1_item.proposal_number), "promise not raised by prepare")
  `LCA_ASSERT_NEXT(a_input_held, s1_valid && !advance, s1_valid && $stable(s1_item), "waiting message lost or overwritten")

endmodule

FILE: verif/tb_lease_consensus_acceptor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lease_consensus_acceptor
// Self-checking bench for the lease acceptor. It drives prepare, propose,
// tick and unused messages through the valid/ready input, predicts every
// reply from its own copy of the acceptor state, and compares each reply
// beat field by field. Both sides idle in random bursts but in the last phase.
// The acceptor ID is changed between phases while the block is drained.
// ----------------------------------------------------------------------------
module tb_lease_consensus_acceptor;
  import lca_pkg::*;

  // The command code that the block must ignore.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 4;

  // Tracks the acceptor state and the replies still owed by the block.
  class acceptor_scoreboard;
    bit [7:0]    own_node;
    bit [31:0]   promised_number;
    bit          lease_held;
    bit [31:0]   held_number;
    bit [7:0]    held_owner;
    bit [23:0]   held_length;
    bit [23:0]   lease_left;
    lca_result_t pending_replies[$];
    int          failures;

    // Apply one accepted message and queue the reply it should cause.
    function void note_message(logic [1:0] cmd, logic [7:0] sender, logic [31:0] number,
                               logic [7:0] owner, logic [23:0] length);
      lca_result_t reply;
      reply = '0;
      reply.destination = sender;
      reply.responder = own_node;
      reply.echoed_proposal = number;
      case (cmd)
        CMD_TICK: begin
          if (lease_held) begin
            if (lease_left <= 24'd1) begin
              lease_left = '0;
              lease_held = 1'b0;
            end else begin
              lease_left = lease_left - 24'd1;
            end
          end
          return;
        end
        CMD_PREPARE: begin
          if (number < promised_number) begin
            reply.reply_kind = KIND_PREP_REJECT;
          end else begin
            promised_number = number;
            if (!lease_held) begin
              reply.reply_kind = KIND_PREP_OPEN;
            end else begin
              reply.reply_kind = KIND_PREP_ACCEPT;
              reply.held_proposal = held_number;
              reply.held_owner = held_owner;
              reply.held_duration = held_length;
            end
          end
        end
        CMD_PROPOSE: begin
          if (number < promised_number) begin
            reply.reply_kind = KIND_PROP_REJECT;
          end else begin
            lease_held = 1'b1;
            held_number = number;
            held_owner = owner;
            held_length = length;
            lease_left = length;
            reply.reply_kind = KIND_PROP_ACCEPT;
          end
        end
        default: return;
      endcase
      pending_replies.push_back(reply);
    endfunction

    function void compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
      if (got_v !== want_v) begin
        $error("%s: expected %0h, got %0h", name, want_v, got_v);
        failures++;
      end
    endfunction

    // Compare one reply beat against the oldest outstanding prediction.
    function void check_reply(lca_result_t got);
      lca_result_t want;
      if (pending_replies.size() == 0) begin
        $error("reply with no request outstanding: reply_kind %0d", got.reply_kind);
        failures++;
        return;
      end
      want = pending_replies.pop_front();
      compare_field("destination", want.destination, got.destination);
      compare_field("responder", want.responder, got.responder);
      compare_field("reply_kind", want.reply_kind, got.reply_kind);
      compare_field("echoed_proposal", want.echoed_proposal, got.echoed_proposal);
      compare_field("held_proposal", want.held_proposal, got.held_proposal);
      compare_field("held_owner", want.held_owner, got.held_owner);
      compare_field("held_duration", want.held_duration, got.held_duration);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  command = '0;
  logic [7:0]  sender_id = '0;
  logic [31:0] proposal_number = '0;
  logic [7:0]  lease_owner = '0;
  logic [23:0] lease_duration = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  destination;
  logic [7:0]  responder;
  logic [2:0]  reply_kind;
  logic [31:0] echoed_proposal;
  logic [31:0] held_proposal;
  logic [7:0]  held_owner;
  logic [23:0] held_duration;

  acceptor_scoreboard sb = new;
  bit no_idle = 1'b0;
  int stall_left = 0;
  int cycle_count = 0;

  lease_consensus_acceptor dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .command         (command),
    .sender_id       (sender_id),
    .proposal_number (proposal_number),
    .lease_owner     (lease_owner),
    .lease_duration  (lease_duration),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .destination     (destination),
    .responder       (responder),
    .reply_kind      (reply_kind),
    .echoed_proposal (echoed_proposal),
    .held_proposal   (held_proposal),
    .held_owner      (held_owner),
    .held_duration   (held_duration)
  );

  always #1 clk = ~clk;

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Output backpressure comes in bursts unless idling is switched off.
  always @(posedge clk) begin
    if (stall_left > 0 && !no_idle) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 19) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Every accepted input beat updates the prediction.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      sb.note_message(command, sender_id, proposal_number, lease_owner, lease_duration);
  end

  // Every accepted output beat is checked.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_reply('{destination, responder, lca_kind_t'(reply_kind), echoed_proposal,
                       held_proposal, held_owner, held_duration});
  end

  // Present one message and return at the edge where it is taken.
  task automatic send_message(input logic [1:0] cmd, input logic [7:0] sender,
                              input logic [31:0] number, input logic [7:0] owner,
                              input logic [23:0] length);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    sender_id <= sender;
    proposal_number <= number;
    lease_owner <= owner;
    lease_duration <= length;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Wait until every reply is in, then let ticks still in flight settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_own_node(input logic [7:0] node);
    cfg_we <= 1'b1;
    cfg_wdata <= node;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.own_node = node;
  endtask

  // Random traffic. Proposal numbers mostly sit at or just above the
  // promise so that leases get granted, held and expire by ticks.
  task automatic run_random(input int count);
    int          pick;
    int          flavor;
    logic [1:0]  cmd;
    logic [31:0] number;
    logic [31:0] base;
    logic [23:0] length;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      flavor = $urandom_range(0, 9);
      base = sb.promised_number;
      number = $urandom;
      length = ($urandom_range(0, 19) == 0) ? 24'($urandom) : 24'($urandom_range(0, 12));
      if (pick < 35) begin
        cmd = CMD_TICK;
      end else if (pick < 40) begin
        cmd = CMD_UNUSED;
      end else if (pick < 70) begin
        cmd = CMD_PREPARE;
        if (flavor < 2)
          number = $urandom_range(0, base);
        else if (base < 32'hFFFF_FFF0)
          number = base + $urandom_range(0, 3);
        else
          number = base;
      end else begin
        cmd = CMD_PROPOSE;
        if (flavor == 2)
          number = (base != 0) ? base - 1 : base;
        else if (flavor > 2)
          number = (base < 32'hFFFF_FFF0) ? base + $urandom_range(0, 2) : base;
      end
      send_message(cmd, 8'($urandom), number, 8'($urandom), length);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed checks with the acceptor ID at zero.
    write_own_node(8'h00);
    send_message(CMD_TICK, 8'h11, 32'd9, 8'h22, 24'd5);         // tick with no lease
    send_message(CMD_PREPARE, 8'h00, 32'd0, 8'h00, 24'd0);      // equal to zero promise
    send_message(CMD_PROPOSE, 8'h00, 32'd0, 8'h00, 24'd0);      // zero-length lease
    send_message(CMD_PREPARE, 8'h01, 32'd0, 8'h00, 24'd0);      // reports zero lease
    send_message(CMD_TICK, 8'h00, 32'd0, 8'h00, 24'd0);         // first tick clears it
    send_message(CMD_PREPARE, 8'hFF, 32'd5, 8'hFF, 24'hFFFFFF);
    send_message(CMD_PREPARE, 8'h02, 32'd4, 8'h00, 24'd0);      // below promise
    send_message(CMD_PROPOSE, 8'h03, 32'd4, 8'h44, 24'd8);      // below promise
    send_message(CMD_PROPOSE, 8'h04, 32'd5, 8'hFF, 24'd3);      // equal to promise
    send_message(CMD_PREPARE, 8'h05, 32'd5, 8'h00, 24'd0);
    send_message(CMD_PROPOSE, 8'h06, 32'd6, 8'h12, 24'hFFFFFF); // replaces held lease
    send_message(CMD_PREPARE, 8'h07, 32'd6, 8'h00, 24'd0);
    send_message(CMD_UNUSED, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 24'hFFFFFF);
    send_message(CMD_PROPOSE, 8'h08, 32'd7, 8'h03, 24'd2);      // re-arms countdown
    send_message(CMD_TICK, 8'h00, 32'd0, 8'h00, 24'd0);
    send_message(CMD_PREPARE, 8'h09, 32'd7, 8'h00, 24'd0);
    send_message(CMD_TICK, 8'h00, 32'd0, 8'h00, 24'd0);         // lease left of one
    send_message(CMD_PREPARE, 8'h0A, 32'd7, 8'h00, 24'd0);
    send_message(CMD_PROPOSE, 8'h0B, 32'd7, 8'h5A, 24'd1);
    send_message(CMD_TICK, 8'h00, 32'd0, 8'h00, 24'd0);
    send_message(CMD_PREPARE, 8'h0C, 32'd8, 8'h00, 24'd0);

    // Random phases under different acceptor IDs.
    wait_drained();
    write_own_node(8'hFF);
    run_random(425);
    wait_drained();
    write_own_node(8'($urandom_range(1, 254)));
    run_random(425);
    wait_drained();
    write_own_node(8'h00);
    run_random(425);

    // Last phase runs without idling and ends at the top of the number range.
    wait_drained();
    no_idle = 1'b1;
    write_own_node(8'h96);
    run_random(425);
    send_message(CMD_PREPARE, 8'h33, 32'hFFFF_FFFF, 8'h00, 24'd0);
    send_message(CMD_PROPOSE, 8'h34, 32'hFFFF_FFFF, 8'hFF, 24'hFFFFFF);
    send_message(CMD_PREPARE, 8'h35, 32'hFFFF_FFFE, 8'h00, 24'd0);
    send_message(CMD_PREPARE, 8'h36, 32'hFFFF_FFFF, 8'h00, 24'd0);

    wait_drained();
    repeat (6) @(posedge clk);
    if (sb.failures == 0 && sb.pending_replies.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
